[rtl/hne_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hne_pkg
// Shared types, constants and the neighbor tap table of the height map
// normal encoder.
// ----------------------------------------------------------------------------
package hne_pkg;

  // Default sizes of the height store.
  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_HEIGHT_BITS = 16;

  // Width of the weighted neighbor difference sums.
  localparam int ACC_W = 20;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WRAP_EDGES = 3'd2;
  localparam logic [2:0] REG_STEP_X     = 3'd3;
  localparam logic [2:0] REG_STEP_Y     = 3'd4;
  localparam logic [2:0] REG_SCALE_Z    = 3'd5;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Code given for both components when the vector length is zero.
  localparam logic [15:0] CODE_MID = 16'd32767;

  // Neighbor offset along one axis: minus one, centre, plus one.
  typedef enum logic [1:0] {
    SEL_M,
    SEL_C,
    SEL_P
  } sel_t;

  // One of the eight neighbor reads with its weights in both sums.
  typedef struct packed {
    sel_t              row;
    sel_t              col;
    logic signed [2:0] sv_w;
    logic signed [2:0] su_w;
  } tap_t;

  // The centre sample carries no weight, so only eight taps are read.
  function automatic tap_t tap_lookup(input logic [2:0] k);
    tap_t t;
    case (k)
      3'd0:    t = '{SEL_M, SEL_M, -3'sd1,  3'sd1};
      3'd1:    t = '{SEL_M, SEL_C, -3'sd2,  3'sd0};
      3'd2:    t = '{SEL_M, SEL_P, -3'sd1, -3'sd1};
      3'd3:    t = '{SEL_C, SEL_M,  3'sd0,  3'sd2};
      3'd4:    t = '{SEL_C, SEL_P,  3'sd0, -3'sd2};
      3'd5:    t = '{SEL_P, SEL_M,  3'sd1,  3'sd1};
      3'd6:    t = '{SEL_P, SEL_C,  3'sd2,  3'sd0};
      default: t = '{SEL_P, SEL_P,  3'sd1, -3'sd1};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/heightmap_normal_encoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_normal_encoder_top
// Height map store with a 3x3 surface normal encoder.
// ----------------------------------------------------------------------------
// Input beats carry a command, a sample position and a height. A write beat
// stores the height and gives no result; the block is ready again in the next
// cycle. A compute beat reads the eight weighted neighbors through the store's
// one read port, scales the sums by the step and scale registers, shifts the
// vector into 31 bits, squares and sums it, and waits for the
// iterative square root and then for the two dividers, which run in parallel;
// when the vector length is zero the dividers are skipped. One item is in work
// at a time. The result sits in an output register, so a new input beat is
// accepted while a stalled result waits; a finished compute waits there until
// the output register is free. Reset restores the register defaults and
// empties the output; the height store is not cleared and must be written
// before use. Configuration writes take effect at once and belong in idle
// periods.
// ----------------------------------------------------------------------------
module heightmap_normal_encoder_top
  import hne_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [7:0]         x,
  input  wire logic [7:0]         y,
  input  wire logic signed [15:0] height,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             normal_x_code,
  output logic [15:0]             normal_y_code
);

  localparam int HB    = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_NORM,
    S_SQ,
    S_SUM,
    S_SQRT,
    S_DIV0,
    S_DIV,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [8:0]  map_width;
  logic [8:0]  map_height;
  logic        wrap_edges;
  logic [15:0] step_x;
  logic [15:0] step_y;
  logic [15:0] scale_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 9'd256;
      map_height <= 9'd256;
      wrap_edges <= 1'b0;
      step_x     <= 16'd256;
      step_y     <= 16'd256;
      scale_z    <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data[8:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[8:0];
        REG_WRAP_EDGES: wrap_edges <= cfg_data[0];
        REG_STEP_X:     step_x     <= cfg_data;
        REG_STEP_Y:     step_y     <= cfg_data;
        REG_SCALE_Z:    scale_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state;
  logic [3:0]  cnt;
  logic [2:0]  tap_prev;
  logic [8:0]  cm, cc, cp, rm, rc, rp;
  logic signed [ACC_W-1:0] sv, su;
  logic [ACC_W-1:0] asv, asu;
  logic        xneg, yneg;
  logic [31:0] pa, pb, pz;
  logic [51:0] mx, my, mz;
  logic [61:0] sqx, sqy, sqz;
  logic [15:0] res_x, res_y;

  // Last valid column and row after saturating the size registers.
  logic [12:0] wlim, hlim;
  logic [8:0]  wm1, hm1;
  logic [8:0]  xc, yc;
  logic [8:0]  cm_n, cp_n, rm_n, rp_n;

  always_comb begin
    if (map_width == 9'd0) begin
      wlim = 13'd0;
    end else if ({4'd0, map_width} > 13'(MAX_WIDTH)) begin
      wlim = 13'(MAX_WIDTH - 1);
    end else begin
      wlim = {4'd0, map_width} - 13'd1;
    end
    if (map_height == 9'd0) begin
      hlim = 13'd0;
    end else if ({4'd0, map_height} > 13'(MAX_HEIGHT)) begin
      hlim = 13'(MAX_HEIGHT - 1);
    end else begin
      hlim = {4'd0, map_height} - 13'd1;
    end
    wm1 = wlim[8:0];
    hm1 = hlim[8:0];
    xc  = ({1'b0, x} > wm1) ? wm1 : {1'b0, x};
    yc  = ({1'b0, y} > hm1) ? hm1 : {1'b0, y};
    // Neighbor coordinates, clamped or wrapped at the edges.
    cm_n = (xc == 9'd0) ? (wrap_edges ? wm1 : 9'd0) : xc - 9'd1;
    cp_n = (xc == wm1)  ? (wrap_edges ? 9'd0 : wm1) : xc + 9'd1;
    rm_n = (yc == 9'd0) ? (wrap_edges ? hm1 : 9'd0) : yc - 9'd1;
    rp_n = (yc == hm1)  ? (wrap_edges ? 9'd0 : hm1) : yc + 9'd1;
  end

  // Store ports: writes in the accept cycle, tap reads during S_READ.
  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   waddr_full, raddr_full;
  logic [HB-1:0] rdata;
  tap_t          tap_cur, tap_old;
  logic [8:0]    rd_row, rd_col;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign mem_we   = accept && (command == CMD_WRITE) &&
                    ({5'd0, x} < 13'(MAX_WIDTH)) && ({5'd0, y} < 13'(MAX_HEIGHT));
  assign waddr_full = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
  assign waddr      = waddr_full[AW-1:0];

  assign tap_cur = tap_lookup(cnt[2:0]);
  assign tap_old = tap_lookup(tap_prev);
  assign mem_re  = (state == S_READ) && (cnt < 4'd8);

  always_comb begin
    case (tap_cur.row)
      SEL_M:   rd_row = rm;
      SEL_C:   rd_row = rc;
      default: rd_row = rp;
    endcase
    case (tap_cur.col)
      SEL_M:   rd_col = cm;
      SEL_C:   rd_col = cc;
      default: rd_col = cp;
    endcase
  end
  assign raddr_full = 32'(rd_row) * 32'(MAX_WIDTH) + 32'(rd_col);
  assign raddr      = raddr_full[AW-1:0];

  hne_height_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (HB),
    .AW     (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (height[HB-1:0]),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Weighted contribution of the sample that just came back.
  logic signed [ACC_W-1:0] samp, sv_term, su_term;

  function automatic logic signed [ACC_W-1:0] weigh(
    input logic signed [ACC_W-1:0] d,
    input logic signed [2:0]       w
  );
    logic signed [ACC_W-1:0] r;
    case (w)
      3'sd2:   r = d <<< 1;
      3'sd1:   r = d;
      -3'sd1:  r = -d;
      -3'sd2:  r = -(d <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign samp    = {{(ACC_W - HB){rdata[HB-1]}}, rdata};
  assign sv_term = weigh(samp, tap_old.sv_w);
  assign su_term = weigh(samp, tap_old.su_w);

  // Square root and component dividers.
  logic        sqrt_start, sqrt_done;
  logic [31:0] len;
  logic        div_start, div_x_done, div_y_done;
  logic [32:0] num_x, num_y;
  logic [15:0] q_x, q_y;

  assign sqrt_start = (state == S_SUM);

  hne_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({2'd0, sqx} + {2'd0, sqy} + {2'd0, sqz}),
    .done     (sqrt_done),
    .root     (len)
  );

  assign div_start = (state == S_DIV0);
  assign num_x = xneg ? {1'b0, len} - {2'd0, mx[30:0]} : {1'b0, len} + {2'd0, mx[30:0]};
  assign num_y = yneg ? {1'b0, len} - {2'd0, my[30:0]} : {1'b0, len} + {2'd0, my[30:0]};

  hne_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .len   (len),
    .done  (div_x_done),
    .quot  (q_x)
  );

  hne_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .len   (len),
    .done  (div_y_done),
    .quot  (q_y)
  );

  // The output register takes a finished result when it is empty or drains.
  logic load_out;

  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (command == CMD_COMPUTE)) begin
            cm    <= cm_n;
            cc    <= xc;
            cp    <= cp_n;
            rm    <= rm_n;
            rc    <= yc;
            rp    <= rp_n;
            sv    <= '0;
            su    <= '0;
            cnt   <= 4'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          tap_prev <= cnt[2:0];
          if (cnt != 4'd0) begin
            sv <= sv + sv_term;
            su <= su + su_term;
          end
          if (cnt == 4'd8) begin
            state <= S_MUL1;
          end
          cnt <= cnt + 4'd1;
        end
        S_MUL1: begin
          pa    <= scale_z * step_y;
          pb    <= scale_z * step_x;
          pz    <= step_x * step_y;
          asv   <= sv[ACC_W-1] ? -sv : sv;
          asu   <= su[ACC_W-1] ? -su : su;
          xneg  <= !sv[ACC_W-1] && (sv != '0);
          yneg  <= su[ACC_W-1];
          state <= S_MUL2;
        end
        S_MUL2: begin
          mx    <= {20'd0, pa} * {32'd0, asv};
          my    <= {20'd0, pb} * {32'd0, asu};
          mz    <= {9'd0, pz, 11'd0};
          state <= S_NORM;
        end
        S_NORM: begin
          // Halve all three until each fits in 31 bits.
          if ((mx[51:31] | my[51:31] | mz[51:31]) != '0) begin
            mx <= mx >> 1;
            my <= my >> 1;
            mz <= mz >> 1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sqx   <= mx[30:0] * mx[30:0];
          sqy   <= my[30:0] * my[30:0];
          sqz   <= mz[30:0] * mz[30:0];
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (len == 32'd0) begin
              res_x <= CODE_MID;
              res_y <= CODE_MID;
              state <= S_OUT;
            end else begin
              state <= S_DIV0;
            end
          end
        end
        S_DIV0: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_x_done && div_y_done) begin
            res_x <= q_x;
            res_y <= q_y;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            normal_x_code <= res_x;
            normal_y_code <= res_y;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/hne_height_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hne_height_mem
// Height sample store: one write port and one read port with a registered
// read.
// ----------------------------------------------------------------------------
module hne_height_mem #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 16,
  parameter int AW     = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/hne_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hne_isqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module hne_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic      [31:0] root
);

  logic        busy;
  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[31:0];

  // One restoring step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        acc  <= '0;
        bitv <= 64'd1 << 62;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/hne_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hne_div
// Component encoder: floor(65535 * num / (2 * len)) by restoring division,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hne_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [31:0] len,
  output logic             done,
  output logic      [15:0] quot
);

  logic        busy;
  logic [3:0]  cnt;
  logic [48:0] rem;
  logic [48:0] dsh;

  // Since num never exceeds 2*len, the quotient fits in 16 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd15;
        rem  <= {num, 16'd0} - {16'd0, num};
        dsh  <= {1'b0, len, 16'd0};
        quot <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[14:0], 1'b1};
        end else begin
          quot <= {quot[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/hne_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hne_checker
// Port-level checks of the height map normal encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hne_checker
  import hne_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] normal_x_code,
  input wire logic [15:0] normal_y_code
);

  // A stalled output beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its codes.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(normal_x_code) && $stable(normal_y_code))
    else $error("output codes changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A write beat gives no result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("result produced by a write beat");

  // A compute beat keeps the input closed while it is in work.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_COMPUTE) |=> !in_ready)
    else $error("input accepted during a compute");

endmodule

bind heightmap_normal_encoder_top hne_checker u_hne_checker (.*);
`default_nettype wire
